FILE: rtl/stereo_cross_modulated_delay_defines.svh
// assertion macros for the stereo cross-modulated delay
// no dependencies
`ifndef STEREO_CROSS_MODULATED_DELAY_DEFINES_SVH
`define STEREO_CROSS_MODULATED_DELAY_DEFINES_SVH
// implication checked on every edge outside reset
`define SCMD_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("scmd check failed");
// next-cycle implication outside reset
`define SCMD_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("scmd check failed");
`endif

FILE: rtl/scmd_pkg.sv
// package for the stereo cross-modulated delay: constants, types, sine table
// no dependencies
package scmd_pkg;
  localparam int HistFrames = 2048;
  localparam int AddrW = $clog2(HistFrames);
  localparam int SineEntries = 1024;
  localparam int SineW = $clog2(SineEntries);
  localparam int QtrW = SineW - 2;
  localparam int QtrEntries = SineEntries / 4;
  localparam int QtrStep = 131072 / SineEntries;
  localparam int MinDelay = 96;
  localparam int SpanDelay = 960;
  localparam logic [31:0] ThirdCycle = 32'd1431655765;
  localparam logic [31:0] SixthCycle = 32'd715827883;
  localparam logic [31:0] QuarterCycle = 32'd1073741824;
  localparam int AmtBase = 51118;
  localparam int AmtSwing = 14418;
  localparam int CfgW = 32;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEPTH_TGT = 3'd0, REG_ROUTING = 3'd1, REG_RATE_TGT = 3'd2,
    REG_START_PH = 3'd3, REG_DEPTH_COEF = 3'd4, REG_ROUTE_COEF = 3'd5,
    REG_RATE_COEF = 3'd6, REG_UNUSED = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_GLIDE, ST_RD_R0, ST_RD_R1, ST_RD_L0, ST_RD_L1,
    ST_MIX_L, ST_MIX_R, ST_OUT_L, ST_OUT_R, ST_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic signed [23:0] wl;
    logic signed [23:0] wr;
    logic [AddrW-1:0]  raddr;
  } mem_ctl_t;

  function automatic logic [31:0] quarter_sine(input logic [31:0] x);
    logic [31:0] x2, t;
    logic [63:0] p;
    x2 = (x * x) >> 15;
    t = (32'd2382 * x2) >> 15;
    t = 32'd21076 - t;
    t = (t * x2) >> 15;
    t = 32'd51472 - t;
    p = ({32'd0, t} * {32'd0, x}) >> 15;
    return (p[31:0] > 32'd32767) ? 32'd32767 : p[31:0];
  endfunction

  // quarter-wave table, evaluated at elaboration
  function automatic logic [QtrEntries*16-1:0] build_qtr_tab();
    logic [QtrEntries*16-1:0] tab;
    logic [31:0] v;
    tab = '0;
    for (int k = 0; k < QtrEntries; k++) begin
      v = quarter_sine(32'(k) * 32'(QtrStep));
      tab[k*16 +: 16] = v[15:0];
    end
    return tab;
  endfunction

  localparam logic [QtrEntries*16-1:0] QtrTab = build_qtr_tab();

  // full-cycle lookup folded onto the quarter table; the quarter point is full scale
  function automatic logic signed [15:0] sine_at(input logic [31:0] ph);
    logic [SineW-1:0] i;
    logic [QtrW-1:0]  k, kr;
    logic [15:0]      mag;
    i = ph[31 -: SineW];
    k = i[QtrW-1:0];
    kr = -k;
    if (!i[SineW-2]) mag = QtrTab[{k, 4'b0} +: 16];
    else if (k == '0) mag = 16'd32767;
    else mag = QtrTab[{kr, 4'b0} +: 16];
    return i[SineW-1] ? -$signed(mag) : $signed(mag);
  endfunction
endpackage

FILE: rtl/scmd_stream_if.sv
// valid/ready stream interface carrying a stereo pair and a bypass flag
// depends on nothing
interface scmd_stream_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] left;
  logic signed [23:0] right;
  logic              mono_bypass;
  modport source (output valid, left, right, mono_bypass, input ready);
  modport sink (input valid, left, right, mono_bypass, output ready);
endinterface

FILE: rtl/scmd_history.sv
// two 2048x24 delay line memories, one write and one read port each
// depends on scmd_pkg
module scmd_history import scmd_pkg::*; (
  input  logic               clk,
  input  mem_ctl_t           ctl,
  output logic signed [23:0] rd_l,
  output logic signed [23:0] rd_r
);
  logic [23:0] mem_l [HistFrames];
  logic [23:0] mem_r [HistFrames];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem_l[ctl.waddr] <= ctl.wl;
      mem_r[ctl.waddr] <= ctl.wr;
    end
    rd_l <= mem_l[ctl.raddr];
    rd_r <= mem_r[ctl.raddr];
  end
endmodule

FILE: rtl/stereo_cross_modulated_delay.sv
// Stereo cross-fed modulated delay. One stereo Q1.23 transaction in gives one
// out. Per sample: glide of depth/routing/rate, LFO advance, then (unless
// bypassed or depth idle) write both delay lines and (when routing is active
// too) read each partner line at two adjacent frames through the shared read
// address, interpolate, mix and crossfade. The sequencer steps through glide,
// the four sequential reads, mix left/right, output left/right and done, where
// the result becomes valid; bypassed or idle samples go from the first read to
// done. A new transaction is taken only once the sequencer is idle and the last
// result has been taken, so a stalled output holds off the input. After reset a
// clearing pass zeroes the delay lines; no transaction is accepted meanwhile.
// Config writes take effect at once; writing start_phase reloads the LFO, but
// not in the glide state, where the phase advance overrides it.
// depends on scmd_pkg, scmd_stream_if, scmd_history, defines header
`include "stereo_cross_modulated_delay_defines.svh"
module stereo_cross_modulated_delay import scmd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  scmd_stream_if.sink         in_s,
  scmd_stream_if.source       out_s,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgW-1:0]     cfg_data
);
  // configuration
  logic [15:0] depth_tgt_r, dcoef_r, rcoef_r, qcoef_r;
  logic        route_on_r;
  logic [31:0] rate_tgt_r;
  // smoothed state
  logic [15:0] depth_r, route_r;
  logic [31:0] rate_r, phase_r;
  logic [AddrW-1:0] wptr_r, clr_r;
  state_t state_r, state_nxt;
  // item registers
  logic signed [23:0] l_r, r_r, first_r, dr_r, dl_r, wl_r, wr_r, ol_r, or_r;
  logic [15:0] frac_r;
  logic [16:0] arl_r, alr_r;
  logic        byp_r, active_r;
  logic        ovalid_r;
  mem_ctl_t    mctl;
  logic signed [23:0] rd_l, rd_r;

  scmd_history u_hist (.clk(clk), .ctl(mctl), .rd_l(rd_l), .rd_r(rd_r));

  // glide one step: |d|*coef>>16, at least 1 unless coef or the difference is zero
  function automatic logic [31:0] glide(input logic [31:0] cur, input logic [31:0] tgt,
                                        input logic [15:0] coef);
    logic [31:0] mag;
    logic [47:0] st;
    mag = (tgt >= cur) ? tgt - cur : cur - tgt;
    st = ({16'd0, mag} * {32'd0, coef}) >> 16;
    if (mag == 0 || coef == 0) return cur;
    if (st == 0) st = 48'd1;
    return (tgt >= cur) ? cur + st[31:0] : cur - st[31:0];
  endfunction

  // read position from the sine-swept delay
  function automatic logic [AddrW+15:0] read_pos(input logic [31:0] ph,
                                                 input logic [AddrW-1:0] wp);
    logic [31:0] d;
    logic [AddrW+16:0] p;
    d = 32'(MinDelay * 65536) + 32'(SpanDelay) * 32'($signed(17'sd32768 + sine_at(ph)));
    if (d < 32'd65536) d = 32'd65536;
    if (d > 32'((HistFrames - 2) * 65536)) d = 32'((HistFrames - 2) * 65536);
    p = {1'b0, wp, 16'd0} + (AddrW+17)'(HistFrames * 65536) - (AddrW+17)'(d);
    return p[AddrW+15:0];
  endfunction

  function automatic logic [16:0] mix_amount(input logic [31:0] ph, input logic [15:0] dep);
    logic signed [31:0] pr;
    logic [31:0] m;
    logic [47:0] a;
    pr = 32'(AmtSwing) * 32'(sine_at(ph));
    m = 32'(AmtBase) + 32'(pr >>> 15);
    a = ({32'd0, dep} * {16'd0, m}) >> 16;
    return (a > 48'd65536) ? 17'd65536 : a[16:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [41:0] v);
    if (v > 42'sd8388607) return 24'sd8388607;
    if (v < -42'sd8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  // interpolate: first + floor((second-first)*frac / 2^16)
  function automatic logic signed [23:0] interp(input logic signed [23:0] a,
      input logic signed [23:0] b, input logic [15:0] f);
    logic signed [41:0] p;
    p = 42'(b - a) * $signed({1'b0, f});
    return 24'(42'(a) + (p >>> 16));
  endfunction

  function automatic logic signed [23:0] mixf(input logic signed [23:0] x,
      input logic signed [23:0] y, input logic [16:0] g);
    logic signed [41:0] p;
    p = (42'(y) - 42'(x)) * $signed({1'b0, g});
    return sat24(42'(x) + (p >>> 16));
  endfunction

  logic [AddrW+15:0] pos_r, pos_l;
  logic [AddrW-1:0]  wptr_inc, wptr_prev;
  logic [16:0]       rw;
  // reads are placed against the frame just written; the pointer has moved on
  assign wptr_prev = wptr_r - 1'b1;
  assign pos_r = read_pos(phase_r, wptr_prev);
  assign pos_l = read_pos(phase_r + ThirdCycle, wptr_prev);
  assign wptr_inc = wptr_r + 1'b1;
  assign rw = (route_r == 16'hFFFF) ? 17'd65536 : {1'b0, route_r};

  assign in_s.ready = (state_r == ST_IDLE) && !ovalid_r;
  assign out_s.valid = ovalid_r;
  assign out_s.left = ol_r;
  assign out_s.right = or_r;
  assign out_s.mono_bypass = 1'b0;

  // memory port control
  always_comb begin
    mctl = '0;
    mctl.waddr = (state_r == ST_CLEAR) ? clr_r : wptr_r;
    mctl.we = (state_r == ST_CLEAR) ||
              (state_r == ST_GLIDE && !byp_r && !(depth_r == 0 && depth_tgt_r == 0));
    mctl.wl = (state_r == ST_CLEAR) ? 24'sd0 : l_r;
    mctl.wr = (state_r == ST_CLEAR) ? 24'sd0 : r_r;
    unique case (state_r)
      ST_RD_R0: mctl.raddr = pos_r[AddrW+15:16];
      ST_RD_R1: mctl.raddr = pos_r[AddrW+15:16] + 1'b1;
      ST_RD_L0: mctl.raddr = pos_l[AddrW+15:16];
      ST_RD_L1: mctl.raddr = pos_l[AddrW+15:16] + 1'b1;
      default:  mctl.raddr = '0;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == AddrW'(HistFrames - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_s.valid && in_s.ready) state_nxt = ST_GLIDE;
      ST_GLIDE: state_nxt = ST_RD_R0;
      ST_RD_R0: state_nxt = active_r ? ST_RD_R1 : ST_DONE;
      ST_RD_R1: state_nxt = ST_RD_L0;
      ST_RD_L0: state_nxt = ST_RD_L1;
      ST_RD_L1: state_nxt = ST_MIX_L;
      ST_MIX_L: state_nxt = ST_MIX_R;
      ST_MIX_R: state_nxt = ST_OUT_L;
      ST_OUT_L: state_nxt = ST_OUT_R;
      ST_OUT_R: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      ovalid_r <= 1'b0;
      depth_tgt_r <= 16'd0; route_on_r <= 1'b0; rate_tgt_r <= 32'd1000;
      dcoef_r <= 16'd68; rcoef_r <= 16'd136; qcoef_r <= 16'd27;
      depth_r <= 16'd0; route_r <= 16'd0; rate_r <= 32'd1000; phase_r <= 32'd0;
      wptr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (out_s.valid && out_s.ready) ovalid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_idx))
          REG_DEPTH_TGT:  depth_tgt_r <= cfg_data[15:0];
          REG_ROUTING:    route_on_r <= cfg_data[0];
          REG_RATE_TGT:   rate_tgt_r <= cfg_data;
          REG_START_PH:   phase_r <= cfg_data;
          REG_DEPTH_COEF: dcoef_r <= cfg_data[15:0];
          REG_ROUTE_COEF: rcoef_r <= cfg_data[15:0];
          REG_RATE_COEF:  qcoef_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: if (in_s.valid && in_s.ready) begin
          depth_r <= 16'(glide({16'd0, depth_r}, {16'd0, depth_tgt_r}, dcoef_r));
          route_r <= 16'(glide({16'd0, route_r}, route_on_r ? 32'hFFFF : 32'd0, rcoef_r));
          rate_r <= glide(rate_r, rate_tgt_r, qcoef_r);
        end
        ST_GLIDE: begin
          phase_r <= phase_r + rate_r;
          if (mctl.we) wptr_r <= wptr_inc;
        end
        ST_DONE: ovalid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath; read data is registered and arrives in the cycle after its address
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (in_s.valid && in_s.ready) begin
        l_r <= in_s.left; r_r <= in_s.right; byp_r <= in_s.mono_bypass;
        ol_r <= in_s.left; or_r <= in_s.right;
      end
      ST_GLIDE: active_r <= mctl.we && !(route_r == 0 && !route_on_r);
      ST_RD_R1: begin
        first_r <= rd_r;
        arl_r <= mix_amount(phase_r + QuarterCycle, depth_r);
      end
      ST_RD_L0: begin
        frac_r <= pos_l[15:0];
        dr_r <= interp(first_r, rd_r, pos_r[15:0]);
      end
      ST_RD_L1: begin
        first_r <= rd_l;
        alr_r <= mix_amount(phase_r + QuarterCycle + SixthCycle, depth_r);
      end
      ST_MIX_L: begin
        dl_r <= interp(first_r, rd_l, frac_r);
        wl_r <= mixf(l_r, dr_r, arl_r);
      end
      ST_MIX_R: wr_r <= mixf(r_r, dl_r, alr_r);
      ST_OUT_L: if (route_r != 0 && depth_r != 0) ol_r <= mixf(l_r, wl_r, rw);
      ST_OUT_R: if (route_r != 0 && depth_r != 0) or_r <= mixf(r_r, wr_r, rw);
      default: ;
    endcase
  end

  `SCMD_ASSERT_IMP(a_no_accept_busy, state_r != ST_IDLE, !in_s.ready)
  `SCMD_ASSERT_NXT(a_accept_starts, in_s.valid && in_s.ready, state_r == ST_GLIDE)
  `SCMD_ASSERT_IMP(a_no_read_in_clear, state_r == ST_CLEAR, !out_s.valid)
endmodule

FILE: test/tb_stereo_cross_modulated_delay.sv
// testbench for the stereo cross-modulated delay: directed and random stereo traffic
// with bursty input and a stalling output, checked against an in-bench predictor
// depends on scmd_pkg, scmd_stream_if and stereo_cross_modulated_delay from rtl
module tb_stereo_cross_modulated_delay;
  timeunit 1ns;
  timeprecision 1ps;
  import scmd_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 40;

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } stereo_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0] cfg_data = '0;

  scmd_stream_if in_if ();
  scmd_stream_if out_if ();

  stereo_cross_modulated_delay i_dut (
    .clk(clk), .rst_n(rst_n), .in_s(in_if), .out_s(out_if),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------- predictor state ----------------
  // configuration copy
  logic [15:0] depth_tgt, depth_coef, route_coef, rate_coef;
  logic        route_on;
  logic [31:0] rate_tgt, phase_init;
  // delay lines and controls
  logic signed [23:0] echo_l [HistFrames];
  logic signed [23:0] echo_r [HistFrames];
  int unsigned  wr_ptr;
  logic [31:0]  lfo_ph, depth_sm, route_sm, rate_sm;
  int           sine_lut [SineEntries];

  stereo_pair_t expected_pairs[$];
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  burst_left = 0;

  // odd polynomial over one quarter of a cycle, x in Q15
  function automatic int quadrant_poly(input longint unsigned x);
    longint unsigned sq, acc;
    sq = (x * x) >> 15;
    acc = 21076 - ((2382 * sq) >> 15);
    acc = 51472 - ((acc * sq) >> 15);
    acc = (acc * x) >> 15;
    return (acc > 32767) ? 32767 : int'(acc);
  endfunction

  function automatic void fill_sine_lut();
    longint unsigned u, x;
    for (int i = 0; i < SineEntries; i++) begin
      u = (longint'(i) * 131072) / SineEntries;
      x = u & 32767;
      case (u >> 15)
        0: sine_lut[i] = quadrant_poly(x);
        1: sine_lut[i] = quadrant_poly(32768 - x);
        2: sine_lut[i] = -quadrant_poly(x);
        default: sine_lut[i] = -quadrant_poly(32768 - x);
      endcase
    end
  endfunction

  function automatic int lfo_sine(input logic [31:0] ph);
    return sine_lut[ph[31 -: SineW]];
  endfunction

  // one-pole glide, at least one lsb per sample unless frozen
  function automatic logic [31:0] glide_toward(input logic [31:0] cur, input logic [31:0] tgt,
                                               input logic [31:0] coef);
    longint diff;
    longint unsigned mag, stp;
    diff = longint'(tgt) - longint'(cur);
    if (diff == 0 || coef == 0) return cur;
    mag = (diff < 0) ? -diff : diff;
    stp = (mag * coef) >> 16;
    if (stp == 0) stp = 1;
    return (diff < 0) ? cur - 32'(stp) : cur + 32'(stp);
  endfunction

  // fractional read of a delay line at a sine-swept delay, linear interpolation
  function automatic longint swept_tap(input bit use_left, input logic [31:0] ph);
    longint unsigned full, dly, pos;
    int unsigned first, second, frac;
    longint a, b;
    full = longint'(HistFrames) << 16;
    dly = longint'(MinDelay) * 65536 + longint'(SpanDelay) * (32768 + lfo_sine(ph));
    if (dly < 65536) dly = 65536;
    if (dly > (longint'(HistFrames - 2) << 16)) dly = longint'(HistFrames - 2) << 16;
    pos = ((longint'(wr_ptr) << 16) + full - dly) % full;
    first = 32'(pos >> 16);
    frac = 32'(pos & 16'hffff);
    second = (first + 1 >= HistFrames) ? 0 : first + 1;
    a = use_left ? echo_l[first] : echo_r[first];
    b = use_left ? echo_l[second] : echo_r[second];
    return a + (((b - a) * longint'(frac)) >>> 16);
  endfunction

  function automatic longint unsigned wet_amount(input logic [31:0] ph);
    longint m;
    longint unsigned amt;
    m = AmtBase + ((longint'(AmtSwing) * lfo_sine(ph)) >>> 15);
    amt = (longint'(depth_sm) * m) >> 16;
    return (amt > 65536) ? 65536 : amt;
  endfunction

  function automatic longint clip24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // advances the predictor by one sample and returns the pair it should give
  function automatic stereo_pair_t weave_sample(input logic signed [23:0] l,
                                                input logic signed [23:0] r, input logic byp);
    stereo_pair_t res;
    logic [31:0] route_t;
    longint dl, dr, wl, wr, rw;
    longint unsigned arl, alr;
    res.left = l;
    res.right = r;
    route_t = route_on ? 32'd65535 : 32'd0;
    depth_sm = glide_toward(depth_sm, {16'd0, depth_tgt}, {16'd0, depth_coef});
    route_sm = glide_toward(route_sm, route_t, {16'd0, route_coef});
    rate_sm = glide_toward(rate_sm, rate_tgt, {16'd0, rate_coef});
    lfo_ph = lfo_ph + rate_sm;
    if (!byp && !(depth_sm == 0 && depth_tgt == 0)) begin
      echo_l[wr_ptr] = l;
      echo_r[wr_ptr] = r;
      if (route_sm == 0 && route_t == 0) begin
        wr_ptr = (wr_ptr + 1 >= HistFrames) ? 0 : wr_ptr + 1;
      end else begin
        dr = swept_tap(1'b0, lfo_ph);
        dl = swept_tap(1'b1, lfo_ph + ThirdCycle);
        arl = wet_amount(lfo_ph + QuarterCycle);
        alr = wet_amount(lfo_ph + QuarterCycle + SixthCycle);
        wr_ptr = (wr_ptr + 1 >= HistFrames) ? 0 : wr_ptr + 1;
        wl = clip24(l + (((dr - l) * longint'(arl)) >>> 16));
        wr = clip24(r + (((dl - r) * longint'(alr)) >>> 16));
        // routing crossfade, full scale counts as unity
        if (route_sm != 0 && depth_sm != 0) begin
          rw = (route_sm == 65535) ? 65536 : longint'(route_sm);
          res.left = 24'(clip24(l + (((wl - l) * rw) >>> 16)));
          res.right = 24'(clip24(r + (((wr - r) * rw) >>> 16)));
        end
      end
    end
    return res;
  endfunction

  // ---------------- stimulus helpers ----------------
  // holds one transaction on the input until accepted, then predicts its result
  task automatic send_pair(input logic signed [23:0] l, input logic signed [23:0] r,
                           input logic byp);
    in_if.valid <= 1'b1;
    in_if.left <= l;
    in_if.right <= r;
    in_if.mono_bypass <= byp;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    expected_pairs.push_back(weave_sample(l, r, byp));
  endtask

  task automatic idle_input(input int n);
    in_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // bursty sender: random burst lengths with random gaps in between
  task automatic send_bursty(input logic signed [23:0] l, input logic signed [23:0] r,
                             input logic byp);
    send_pair(l, r, byp);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      case ($urandom_range(0, 3))
        0: ;
        1, 2: idle_input($urandom_range(1, 6));
        default: idle_input($urandom_range(10, 40));
      endcase
    end else begin
      burst_left--;
    end
  endtask

  // config writes only with nothing in flight
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    in_if.valid <= 1'b0;
    wait (expected_pairs.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEPTH_TGT: depth_tgt = val[15:0];
      REG_ROUTING: route_on = val[0];
      REG_RATE_TGT: rate_tgt = val;
      REG_START_PH: begin
        phase_init = val;
        lfo_ph = val;
      end
      REG_DEPTH_COEF: depth_coef = val[15:0];
      REG_ROUTE_COEF: route_coef = val[15:0];
      REG_RATE_COEF: rate_coef = val[15:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      2: return 24'(int'($urandom_range(0, 64)) - 32);
      default: return 24'($urandom);
    endcase
  endfunction

  // ---------------- result checking ----------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    stereo_pair_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch("unexpected transaction, left", out_if.left, 0);
      end else begin
        want = expected_pairs.pop_front();
        if (out_if.left !== want.left) report_mismatch("left_out", out_if.left, want.left);
        if (out_if.right !== want.right) report_mismatch("right_out", out_if.right, want.right);
      end
    end
  end

  // receiver stall pattern: cycles through four modes, includes no-stall stretches
  always @(posedge clk) begin
    case ((cycle_count / 200) % 4)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(0, 1) == 1);
      2: out_if.ready <= (cycle_count % 7 == 0);
      default: out_if.ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- tests ----------------
  // extremes and bypass with the reset configuration (depth idle: dry, no write)
  task automatic test_reset_extremes();
    send_pair(24'sh7fffff, 24'sh800000, 1'b0);
    send_pair(24'sh800000, 24'sh7fffff, 1'b1);
    send_pair(24'sh000000, 24'shffffff, 1'b0);
    send_pair(24'sh555555, 24'shaaaaaa, 1'b1);
  endtask

  // routing idle: depth up, routing off, pairs written and pointer advances
  task automatic test_routing_idle();
    write_reg(REG_DEPTH_TGT, 32'hffff);
    write_reg(REG_DEPTH_COEF, 32'hffff);
    for (int i = 0; i < 4; i++) send_pair(rand_sample(), rand_sample(), 1'b0);
  endtask

  // partial idle: routing target on but frozen routing glide keeps it at zero
  task automatic test_partial_idle();
    write_reg(REG_ROUTE_COEF, 32'h0);
    write_reg(REG_ROUTING, 32'h1);
    for (int i = 0; i < 3; i++) send_pair(rand_sample(), rand_sample(), 1'b0);
    send_pair(24'sh7fffff, 24'sh800000, 1'b1);
  endtask

  // routing glides almost to full wet on the first pair, fast rate, extremes through the mix
  task automatic test_full_wet();
    write_reg(REG_ROUTE_COEF, 32'hffff);
    write_reg(REG_RATE_COEF, 32'hffff);
    write_reg(REG_RATE_TGT, 32'hffffffff);
    write_reg(REG_START_PH, 32'hffffffff);
    send_pair(24'sh7fffff, 24'sh800000, 1'b0);
    send_pair(24'sh800000, 24'sh7fffff, 1'b0);
    send_pair(24'sh7fffff, 24'sh7fffff, 1'b0);
    send_pair(24'sh800000, 24'sh800000, 1'b1);
  endtask

  // zero rate target glides to a frozen phase; depth fades toward zero
  task automatic test_zero_rate();
    write_reg(REG_RATE_TGT, 32'h0);
    write_reg(REG_START_PH, 32'h0);
    write_reg(REG_DEPTH_TGT, 32'h0);
    write_reg(REG_DEPTH_COEF, 32'h4000);
    for (int i = 0; i < 6; i++) send_pair(rand_sample(), rand_sample(), 1'b0);
  endtask

  // random phases, each with its own configuration, bursty traffic
  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_DEPTH_TGT, (p == 0) ? 32'hffff : $urandom_range(0, 65535));
      write_reg(REG_ROUTING, (p == 3) ? 0 : 1);
      write_reg(REG_RATE_TGT, (p == 1) ? 32'd1 : (p == 2) ? 32'hffffffff : $urandom);
      write_reg(REG_START_PH, $urandom);
      write_reg(REG_DEPTH_COEF, (p == 4) ? 32'h0 : $urandom_range(1, 65535));
      write_reg(REG_ROUTE_COEF, (p == 2) ? 32'h1 : $urandom_range(1, 65535));
      write_reg(REG_RATE_COEF, (p == 5) ? 32'h0 : $urandom_range(0, 65535));
      burst_left = 0;
      for (int i = 0; i < 180; i++)
        send_bursty(rand_sample(), rand_sample(), $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.left = '0;
    in_if.right = '0;
    in_if.mono_bypass = 1'b0;
    out_if.ready = 1'b0;
    fill_sine_lut();
    // predictor reset state
    depth_tgt = 16'd0; route_on = 1'b0; rate_tgt = 32'd1000; phase_init = 32'd0;
    depth_coef = 16'd68; route_coef = 16'd136; rate_coef = 16'd27;
    foreach (echo_l[i]) begin
      echo_l[i] = '0;
      echo_r[i] = '0;
    end
    wr_ptr = 0;
    lfo_ph = phase_init;
    depth_sm = '0;
    route_sm = '0;
    rate_sm = rate_tgt;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_extremes();
    test_routing_idle();
    test_partial_idle();
    test_full_wet();
    test_zero_rate();
    test_random_phases();

    idle_input(1);
    wait (expected_pairs.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
